### hdl/omre_pkg.sv
// Package: shared constants, types and op codes for the ordered multiset rank engine.
package omre_pkg;
   localparam int Capacity = 1024;
   localparam int AddrW = $clog2(Capacity);
   localparam int CountW = $clog2(Capacity + 1);

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_REMOVE = 3'd1,
      OP_RANK   = 3'd2,
      OP_SELECT = 3'd3,
      OP_PRED   = 3'd4,
      OP_SUCC   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      logic [AddrW-1:0] addr;
      logic             wen;
      logic [31:0]      wdata;
   } mem_req_type;
endpackage

### hdl/omre_ram.sv
// Generic single-port synchronous RAM with registered read data.
module omre_ram #(
   parameter int Depth = 1024,
   parameter int Width = 32
) (
   input  logic                     clock,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic                     wen,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wen) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

### hdl/omre_ctrl.sv
// Sequencer: binary search, then element shift for insert and remove, then result for one request word.
module omre_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           op,
   input  logic [31:0]          operand,
   input  logic [31:0]          rdata,
   output omre_pkg::mem_req_type mreq,
   output logic                 busy,
   output logic                 done,
   output logic [31:0]          answer,
   output logic [1:0]           status
);
   import omre_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SRCH  = 7'b0000010,
      S_SWAIT = 7'b0000100,
      S_DEC   = 7'b0001000,
      S_MV    = 7'b0010000,
      S_MVW   = 7'b0100000,
      S_RD    = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic [31:0]      v_ff, v_in;
   logic [CountW-1:0] cnt_ff, cnt_in, lo_ff, lo_in, hi_ff, hi_in, i_ff, i_in;
   logic [31:0]      hold_ff, hold_in, ans_in;
   logic [1:0]       st_in;
   logic             done_in;
   logic [CountW-1:0] mid;
   logic             strict, go_right, v_ok;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign strict = (op_ff == OP_INSERT) || (op_ff == OP_SUCC);
   assign go_right = strict ? ($signed(rdata) <= $signed(v_ff))
                            : ($signed(rdata) < $signed(v_ff));
   assign v_ok = !v_ff[31] && (v_ff != 32'd0) && (v_ff[30:0] <= 31'(cnt_ff));
   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff; op_in = op_ff; v_in = v_ff; cnt_in = cnt_ff;
      lo_in = lo_ff; hi_in = hi_ff; i_in = i_ff; hold_in = hold_ff;
      ans_in = answer; st_in = status; done_in = 1'b0;
      mreq = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = op; v_in = operand; lo_in = '0; hi_in = cnt_ff;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               mreq.addr = mid[AddrW-1:0];
               state_in = S_SWAIT;
            end else begin
               state_in = S_DEC;
               mreq.addr = lo_ff[AddrW-1:0];
               if (op_ff == OP_PRED) mreq.addr = AddrW'(lo_ff - 1'b1);
               if (op_ff == OP_SELECT) mreq.addr = AddrW'(v_ff - 32'd1);
            end
         end
         S_SWAIT: begin
            if (go_right) lo_in = mid + 1'b1;
            else hi_in = mid;
            state_in = S_SRCH;
         end
         S_DEC: begin
            ans_in = '0; st_in = ST_OK; done_in = 1'b1; state_in = S_IDLE;
            case (op_ff)
               OP_INSERT: begin
                  if (cnt_ff >= CountW'(Capacity)) st_in = ST_FULL;
                  else begin
                     done_in = 1'b0; i_in = cnt_ff; hold_in = v_ff;
                     cnt_in = cnt_ff + 1'b1; state_in = S_MV;
                  end
               end
               OP_REMOVE: begin
                  if (lo_ff < cnt_ff && rdata == v_ff) begin
                     done_in = 1'b0; i_in = lo_ff; cnt_in = cnt_ff - 1'b1;
                     state_in = S_MV;
                  end else st_in = ST_NOTFOUND;
               end
               OP_RANK: ans_in = 32'(lo_ff) + 32'd1;
               OP_SELECT: begin
                  if (v_ok) ans_in = rdata; else st_in = ST_NOTFOUND;
               end
               OP_PRED: begin
                  if (lo_ff == '0) st_in = ST_NOTFOUND; else ans_in = rdata;
               end
               OP_SUCC: begin
                  if (lo_ff >= cnt_ff) st_in = ST_NOTFOUND; else ans_in = rdata;
               end
               default: ;
            endcase
         end
         S_MV: begin
            // insert: walk down from the tail; remove: walk up to the new tail
            if (op_ff == OP_INSERT) begin
               if (i_ff > lo_ff) begin
                  mreq.addr = AddrW'(i_ff - 1'b1); state_in = S_MVW;
               end else begin
                  mreq.addr = i_ff[AddrW-1:0]; mreq.wen = 1'b1;
                  mreq.wdata = v_ff; done_in = 1'b1; state_in = S_IDLE;
               end
            end else begin
               if (i_ff < cnt_ff) begin
                  mreq.addr = AddrW'(i_ff + 1'b1); state_in = S_MVW;
               end else begin
                  done_in = 1'b1; state_in = S_IDLE;
               end
            end
         end
         S_MVW: begin
            hold_in = rdata; state_in = S_RD;
         end
         S_RD: begin
            mreq.addr = i_ff[AddrW-1:0]; mreq.wen = 1'b1; mreq.wdata = hold_ff;
            i_in = (op_ff == OP_INSERT) ? i_ff - 1'b1 : i_ff + 1'b1;
            state_in = S_MV;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; done <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; done <= done_in;
      end
      op_ff <= op_in; v_ff <= v_in; lo_ff <= lo_in; hi_ff <= hi_in;
      i_ff <= i_in; hold_ff <= hold_in; answer <= ans_in; status <= st_in;
   end
endmodule

### hdl/ordered_multiset_rank_engine_unit.sv
// Top level: ordered multiset rank engine with stream request and response channels.
// Usage:
//   req_tdata carries one request word: op in bits [2:0], operand in [34:3].
//   rsp_tdata returns answer in [31:0] and status in [33:32], one per request.
//   The sorted elements live in a single-port RAM with registered read data.
//   A request runs a binary search of k probes (k at most floor(log2(count))+1),
//   each probe a RAM read then a compare, then a read of the answer cell and a
//   decide step; its result is registered as done, then in the output register.
//   Insert and remove also shift the tail, each moved element read, captured and
//   written back in turn, then a final step; for insert it writes the new value.
//   One request is processed at a time; req_tready is low while it runs and in
//   the cycle its result is loaded into the output register.
//   A waiting response word holds req_tready low until rsp_tready takes it, so
//   a stalled receiver stalls the engine; the next request can be accepted at
//   the same edge the response word is taken.
//   Reset empties the store at once (count to zero); no clearing pass.
//   Unused op codes return answer zero with status ok.
module ordered_multiset_rank_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // op[2:0], operand[34:3], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // answer[31:0], status[33:32], zero fill
);
   import omre_pkg::*;

   mem_req_type mreq;
   logic [31:0] rdata, answer;
   logic [1:0]  status;
   logic        busy, done, start;
   logic        vld_ff;
   logic [33:0] out_ff;

   assign req_tready = !busy && !done && (!vld_ff || rsp_tready);
   assign start = req_tvalid && req_tready;

   omre_ctrl u_ctrl (
      .clock, .reset, .start,
      .op(req_tdata[2:0]), .operand(req_tdata[34:3]),
      .rdata, .mreq, .busy, .done, .answer, .status
   );

   omre_ram #(.Depth(Capacity), .Width(32)) u_ram (
      .clock, .addr(mreq.addr), .wen(mreq.wen), .wdata(mreq.wdata), .rdata
   );

   // done pulses one cycle; next request is held off until the slot frees
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (done) begin
         vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         vld_ff <= 1'b0;
      end
      if (done) out_ff <= {status, answer};
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = {6'd0, out_ff};
endmodule

### hdl/omre_checker.sv
// Port checker for the ordered multiset rank engine, bound to the top level.
module omre_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] != 2'd3)
      else $error("illegal status");
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !rsp_tvalid || $past(rsp_tvalid))
      else $error("response in the cycle after accept");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:34] == 6'd0)
      else $error("fill bits set");
endmodule

bind ordered_multiset_rank_engine_unit omre_checker u_omre_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

### tb/tb_ordered_multiset_rank_engine_unit.sv
// Testbench for the ordered multiset rank engine against a sorted-array predictor.
`timescale 1ns / 1ps
module tb_ordered_multiset_rank_engine_unit;
   import omre_pkg::*;

   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] operand;
   } request_type;

   typedef struct packed {
      logic [31:0] answer;
      logic [1:0]  status;
   } response_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   int           shadow_set[$];
   int           error_count;
   int           accepted_count;
   int           total_requests;
   bit           calm_phase;
   int           send_gap;
   int           recv_gap;
   int           hold_off_cycles;
   bit           req_tready_seen;

   ordered_multiset_rank_engine_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // count of elements strictly below (or at or below, when inclusive) value
   function automatic int count_below(int value, bit inclusive);
      int n;
      n = 0;
      foreach (shadow_set[i]) begin
         if (shadow_set[i] < value || (inclusive && shadow_set[i] == value)) n++;
      end
      return n;
   endfunction

   function automatic response_type predict_response(request_type rq);
      response_type rs;
      int value;
      int p;
      value = $signed(rq.operand);
      rs.answer = '0;
      rs.status = ST_OK;
      case (rq.op)
         OP_INSERT: begin
            if (shadow_set.size() >= Capacity) rs.status = ST_FULL;
            else shadow_set.insert(count_below(value, 1'b1), value);
         end
         OP_REMOVE: begin
            p = count_below(value, 1'b0);
            if (p < shadow_set.size() && shadow_set[p] == value) shadow_set.delete(p);
            else rs.status = ST_NOTFOUND;
         end
         OP_RANK: rs.answer = count_below(value, 1'b0) + 1;
         OP_SELECT: begin
            if (value < 1 || value > shadow_set.size()) rs.status = ST_NOTFOUND;
            else rs.answer = shadow_set[value - 1];
         end
         OP_PRED: begin
            p = count_below(value, 1'b0);
            if (p == 0) rs.status = ST_NOTFOUND;
            else rs.answer = shadow_set[p - 1];
         end
         OP_SUCC: begin
            p = count_below(value, 1'b1);
            if (p >= shadow_set.size()) rs.status = ST_NOTFOUND;
            else rs.answer = shadow_set[p];
         end
         default: ;
      endcase
      return rs;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000 + $urandom_range(0, 3);
         1: return 32'h7fff_ffff - $urandom_range(0, 3);
         2: return $urandom();
         default: return $urandom_range(0, 40) - 20;
      endcase
   endfunction

   task automatic add_request(logic [2:0] op, logic [31:0] operand);
      request_type rq;
      rq.op = op;
      rq.operand = operand;
      pending_requests.push_back(rq);
      total_requests++;
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready_seen) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_tdata <= {5'b0, pending_requests[0].operand, pending_requests[0].op};
            pending_requests.pop_front();
            req_tvalid <= 1'b1;
            if (!calm_phase && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 10);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_tready_seen <= 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         request_type rq;
         rq.op = req_tdata[2:0];
         rq.operand = req_tdata[34:3];
         expected_responses.push_back(predict_response(rq));
         accepted_count++;
         req_tready_seen <= 1'b1;
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm_phase && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 10);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_responses.size() == 0) begin
            $error("unexpected word: answer %0d status %0d",
                   $signed(rsp_tdata[31:0]), rsp_tdata[33:32]);
            error_count++;
         end else begin
            response_type ex;
            ex = expected_responses.pop_front();
            if (rsp_tdata[31:0] !== ex.answer) begin
               $error("answer: expected %0d, actual %0d",
                      $signed(ex.answer), $signed(rsp_tdata[31:0]));
               error_count++;
            end
            if (rsp_tdata[33:32] !== ex.status) begin
               $error("status: expected %0d, actual %0d", ex.status, rsp_tdata[33:32]);
               error_count++;
            end
         end
      end
   end

   initial begin
      int n;
      int base;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      req_tready_seen = 1'b0;
      send_gap = 0;
      recv_gap = 0;
      hold_off_cycles = 0;
      calm_phase = 1'b0;
      error_count = 0;
      accepted_count = 0;
      total_requests = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty-store queries, extremes, duplicates, unused ops
      add_request(OP_REMOVE, 32'd5);
      add_request(OP_SELECT, 32'd1);
      add_request(OP_PRED, 32'd0);
      add_request(OP_SUCC, 32'd0);
      add_request(OP_RANK, 32'h8000_0000);
      add_request(OP_INSERT, 32'h8000_0000);
      add_request(OP_INSERT, 32'h7fff_ffff);
      add_request(OP_INSERT, 32'd7);
      add_request(OP_INSERT, 32'd7);
      add_request(OP_RANK, 32'h7fff_ffff);
      add_request(OP_RANK, 32'd8);
      add_request(OP_SELECT, 32'd0);
      add_request(OP_SELECT, 32'hffff_ffff);
      add_request(OP_SELECT, 32'd4);
      add_request(OP_SELECT, 32'd5);
      add_request(OP_SELECT, 32'h8000_0000);
      add_request(OP_PRED, 32'h8000_0000);
      add_request(OP_SUCC, 32'h7fff_ffff);
      add_request(OP_PRED, 32'd7);
      add_request(OP_SUCC, 32'd7);
      add_request(OP_SPARE_A, 32'hffff_ffff);
      add_request(OP_SPARE_B, 32'h5555_aaaa);
      add_request(OP_REMOVE, 32'd7);
      add_request(OP_REMOVE, 32'd8);

      // long receiver hold-off with the sender still offering words
      wait (pending_requests.size() == 0);
      hold_off_cycles = 300;
      for (n = 0; n < 20; n++) add_request(OP_RANK, pick_value());

      // random mix, insert-heavy early
      for (n = 0; n < 400; n++) begin
         if (n == 350) begin
            wait (pending_requests.size() < 4);
            calm_phase = 1'b1;
         end
         base = $urandom_range(0, 9);
         if (n < 150 && base < 5) add_request(OP_INSERT, pick_value());
         else if (base < 2) add_request(OP_REMOVE, pick_value());
         else if (base < 4) add_request(OP_SELECT, $urandom_range(0, 5) == 0 ?
                                         $urandom() : $urandom_range(0, 160));
         else if (base < 9) add_request(3'($urandom_range(0, 5)), pick_value());
         else add_request(3'($urandom_range(0, 7)), $urandom());
         if (pending_requests.size() > 16) wait (pending_requests.size() < 8);
      end

      wait (pending_requests.size() == 0);
      wait (accepted_count == total_requests);
      add_request(OP_INSERT, 32'd1);
      add_request(OP_SELECT, 32'd1);
      add_request(OP_RANK, 32'h7fff_ffff);
      add_request(OP_REMOVE, 32'd50);
      add_request(OP_INSERT, 32'h8000_0000);
      add_request(OP_INSERT, 32'd3);
      add_request(OP_SUCC, 32'h8000_0000);

      wait (pending_requests.size() == 0);
      wait (accepted_count == total_requests);
      wait (expected_responses.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("tb_ordered_multiset_rank_engine_unit: done, clean");
      else $display("tb_ordered_multiset_rank_engine_unit: done, errors");
      $finish;
   end

   initial begin
      #60ms;
      $display("tb_ordered_multiset_rank_engine_unit: done, errors");
      $finish;
   end
endmodule
